### rtl/matrix_ring_rotate_by_one_assert.svh
// Assertion macros for the ring rotation block.
// Each macro takes a label, a clock, a reset, an antecedent, a consequent and a message.
`ifndef MATRIX_RING_ROTATE_BY_ONE_ASSERT_SVH
`define MATRIX_RING_ROTATE_BY_ONE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define MRR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define MRR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mrr_pkg.sv
package mrr_pkg;

  // Matrix geometry
  localparam int MAX_ROWS = 16;
  localparam int MAX_COLS = 16;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int COUNT_W  = 5;
  localparam int DATA_W   = 32;
  localparam int CFG_IDX_W = 1;

  // Reset counts
  localparam logic [COUNT_W-1:0] ROW_COUNT_RST = COUNT_W'(4);
  localparam logic [COUNT_W-1:0] COL_COUNT_RST = COUNT_W'(4);

  // Item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_RESULT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture the item
    logic exec;   // do the memory access
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_read;
  } dp_status_t;

  // Zero counts as one, anything past the bound is the bound
  function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v,
                                                     input logic [COUNT_W-1:0] bound);
    logic [COUNT_W-1:0] x;
    x = v;
    if (x == '0) x = COUNT_W'(1);
    if (x > bound) x = bound;
    return x;
  endfunction

endpackage

### rtl/mrr_ctrl.sv
module mrr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  mrr_pkg::dp_status_t status,
  output mrr_pkg::dp_cmd_t    cmd,
  output logic                busy,
  output logic                done
);

  mrr_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mrr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      mrr_pkg::ST_IDLE: begin
        if (start) state_next = mrr_pkg::ST_ACCESS;
      end
      mrr_pkg::ST_ACCESS: begin
        if (status.is_read) state_next = mrr_pkg::ST_RESULT;
        else                state_next = mrr_pkg::ST_IDLE;
      end
      mrr_pkg::ST_RESULT: begin
        state_next = mrr_pkg::ST_IDLE;
      end
      default: state_next = mrr_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      mrr_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      mrr_pkg::ST_ACCESS: begin
        cmd.exec = 1'b1;
      end
      mrr_pkg::ST_RESULT: begin
        done = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

### rtl/mrr_datapath.sv
module mrr_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  mrr_pkg::dp_cmd_t                    cmd,
  output mrr_pkg::dp_status_t                 status,
  input  logic                                cfg_write,
  input  logic [mrr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mrr_pkg::COUNT_W-1:0]         cfg_data,
  input  logic                                kind,
  input  logic [mrr_pkg::ROW_W-1:0]           row_index,
  input  logic [mrr_pkg::COL_W-1:0]           column_index,
  input  logic signed [mrr_pkg::DATA_W-1:0]   element_value,
  output logic signed [mrr_pkg::DATA_W-1:0]   rotated_value
);

  logic [mrr_pkg::COUNT_W-1:0] row_count, col_count;

  logic                        kind_q;
  logic [mrr_pkg::ROW_W-1:0]   r_q;
  logic [mrr_pkg::COL_W-1:0]   c_q;
  logic [mrr_pkg::DATA_W-1:0]  val_q;

  logic [mrr_pkg::DATA_W-1:0]  mem [mrr_pkg::DEPTH];
  logic [mrr_pkg::DATA_W-1:0]  rdata;
  logic                        outside_q;

  logic [mrr_pkg::COUNT_W-1:0] r_ext, c_ext, r_far, c_far, k_rc, k_far, k;
  logic [mrr_pkg::COUNT_W-1:0] bottom, right;
  logic [mrr_pkg::ROW_W-1:0]   sr;
  logic [mrr_pkg::COL_W-1:0]   sc;
  logic                        in_range;
  logic [mrr_pkg::ADDR_W-1:0]  addr;

  // Count registers, clamped on write
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= mrr_pkg::ROW_COUNT_RST;
      col_count <= mrr_pkg::COL_COUNT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mrr_pkg::REG_ROW_COUNT:
          row_count <= mrr_pkg::clamp_count(cfg_data, mrr_pkg::COUNT_W'(mrr_pkg::MAX_ROWS));
        mrr_pkg::REG_COL_COUNT:
          col_count <= mrr_pkg::clamp_count(cfg_data, mrr_pkg::COUNT_W'(mrr_pkg::MAX_COLS));
        default: ;
      endcase
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (rst) begin
      kind_q <= mrr_pkg::KIND_WRITE;
    end else if (cmd.load) begin
      kind_q <= kind;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_q   <= row_index;
      c_q   <= column_index;
      val_q <= element_value;
    end
  end

  assign status.is_read = (kind_q == mrr_pkg::KIND_READ);

  // Source position in the stored matrix for the rotated view
  always_comb begin
    r_ext    = mrr_pkg::COUNT_W'(r_q);
    c_ext    = mrr_pkg::COUNT_W'(c_q);
    in_range = (r_ext < row_count) && (c_ext < col_count);
    r_far    = row_count - mrr_pkg::COUNT_W'(1) - r_ext;
    c_far    = col_count - mrr_pkg::COUNT_W'(1) - c_ext;
    k_rc     = (r_ext < c_ext) ? r_ext : c_ext;
    k_far    = (r_far < c_far) ? r_far : c_far;
    k        = (k_rc < k_far) ? k_rc : k_far;
    bottom   = row_count - mrr_pkg::COUNT_W'(1) - k;
    right    = col_count - mrr_pkg::COUNT_W'(1) - k;
    sr       = r_q;
    sc       = c_q;
    // only rings of at least two rows and two columns move
    if (bottom > k && right > k) begin
      if (r_ext == k) begin
        if (c_ext > k) sc = c_q - mrr_pkg::COL_W'(1);
        else           sr = r_q + mrr_pkg::ROW_W'(1);
      end else if (c_ext == right) begin
        sr = r_q - mrr_pkg::ROW_W'(1);
      end else if (r_ext == bottom) begin
        sc = c_q + mrr_pkg::COL_W'(1);
      end else if (c_ext == k) begin
        sr = r_q + mrr_pkg::ROW_W'(1);
      end
    end
    // row-major, MAX_COLS words per row
    if (status.is_read) addr = {sr, sc};
    else                addr = {r_q, c_q};
  end

  // Matrix store
  always_ff @(posedge clk) begin
    if (cmd.exec && !status.is_read && in_range) begin
      mem[addr] <= val_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rdata     <= mem[addr];
      outside_q <= !in_range;
    end
  end

  // Reads outside the active matrix return zero
  assign rotated_value = outside_q ? '0 : $signed(rdata);

endmodule

### rtl/matrix_ring_rotate_by_one.sv
// Ring-rotated matrix store. A write item passes through accept, then the
// memory write; a read item through accept, mapped memory read, then result.
// The matrix memory has a single port and 256 words. busy stays high while
// an item is at work; a new item is taken on the edge where start is high and
// busy is low. Each read gives one result: rotated_value is valid in the single
// cycle that done is high, and is not held, so the receiver must take it then.
// Writes outside the active rows and columns are dropped, reads there return 0.
// Counts may be changed only while busy is low.
module matrix_ring_rotate_by_one (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                kind,
  input  logic [mrr_pkg::ROW_W-1:0]           row_index,
  input  logic [mrr_pkg::COL_W-1:0]           column_index,
  input  logic signed [mrr_pkg::DATA_W-1:0]   element_value,
  output logic                                done,
  output logic signed [mrr_pkg::DATA_W-1:0]   rotated_value,
  input  logic                                cfg_write,
  input  logic [mrr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mrr_pkg::COUNT_W-1:0]         cfg_data
);

  mrr_pkg::dp_cmd_t    cmd;
  mrr_pkg::dp_status_t status;

  mrr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  mrr_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .kind          (kind),
    .row_index     (row_index),
    .column_index  (column_index),
    .element_value (element_value),
    .rotated_value (rotated_value)
  );

  // Checks
`include "matrix_ring_rotate_by_one_assert.svh"

  `MRR_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accepted item not busy")
  `MRR_ASSERT_NOW(a_done_busy, clk, rst, done, busy, "result strobe while idle")
  `MRR_ASSERT_NEXT(a_done_single, clk, rst, done, !done && !busy, "result strobe held")
  `MRR_ASSERT_NEXT(a_idle_no_done, clk, rst, !busy, !done, "result without memory access")

endmodule
